/* hdl/sst_pkg.sv */
// shared constants, codes and types of the scoped symbol table
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

   // table dimensions
   localparam int MAX_ENTRIES = 64;
   localparam int MAX_SCOPES  = 16;
   localparam int KEY_BITS    = 32;

   // variable addresses per scope
   localparam int ADDR_LIMIT = 64;

   // fixed field widths of the channels
   localparam int CMD_W       = 2;
   localparam int KEY_IN_W    = 32;
   localparam int TYPE_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int LEVEL_W     = 4;
   localparam int ADDR_W      = 6;
   localparam int DEPTH_OUT_W = 5;

   // derived internal widths
   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int INDEX_W = $clog2(MAX_ENTRIES);
   localparam int DEPTH_W = $clog2(MAX_SCOPES + 1);
   localparam int SCOPE_W = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
   localparam int ACNT_W  = $clog2(ADDR_LIMIT + 1);

   // item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN    = 2'd0,
      CMD_CLOSE   = 2'd1,
      CMD_DECLARE = 2'd2,
      CMD_FIND    = 2'd3
   } cmd_code_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_TWICE   = 3'd1,
      ST_UNDECL  = 3'd2,
      ST_FULL    = 3'd3,
      ST_NOSCOPE = 3'd4
   } status_type;

   // object kinds and types
   localparam logic              KIND_VAR   = 1'b0;
   localparam logic              KIND_PROC  = 1'b1;
   localparam logic [TYPE_W-1:0] TYPE_UNDEF = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_INT   = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_BOOL  = 2'd2;

   // attributes of one stored entry
   typedef struct packed {
      logic [SCOPE_W-1:0] scope;
      logic               kind;
      logic [TYPE_W-1:0]  typ;
      logic [ADDR_W-1:0]  addr;
   } attr_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_step;
      logic commit;
   } sst_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_busy;
   } sst_stat_type;

endpackage

`default_nettype wire

/* hdl/sst_req_if.sv */
// request channel interface of the scoped symbol table
`timescale 1ns / 1ps
`default_nettype none

interface sst_req_if import sst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [KEY_IN_W-1:0] name_key;
   logic                obj_kind;
   logic [TYPE_W-1:0]   obj_type;

   modport source (output valid, command, name_key, obj_kind, obj_type, input ready);
   modport sink   (input valid, command, name_key, obj_kind, obj_type, output ready);
endinterface

`default_nettype wire

/* hdl/sst_rsp_if.sv */
// response channel interface of the scoped symbol table
`timescale 1ns / 1ps
`default_nettype none

interface sst_rsp_if import sst_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic                   found_kind;
   logic [TYPE_W-1:0]      found_type;
   logic [LEVEL_W-1:0]     found_level;
   logic [ADDR_W-1:0]      found_addr;
   logic [DEPTH_OUT_W-1:0] depth;

   modport source (output valid, status, found_kind, found_type, found_level, found_addr,
                   depth, input ready);
   modport sink   (input valid, status, found_kind, found_type, found_level, found_addr,
                   depth, output ready);
endinterface

`default_nettype wire

/* hdl/sst_ctrl.sv */
// control state machine of the scoped symbol table
`timescale 1ns / 1ps
`default_nettype none

module sst_ctrl import sst_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output sst_cmd_type       cmd,
   input  wire sst_stat_type stat
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // commands to the datapath
   always_comb begin
      cmd            = '0;
      cmd.accept     = (state_ff == S_IDLE) && ready_ff && req_valid;
      cmd.scan_start = (state_ff == S_START);
      cmd.scan_step  = (state_ff == S_SCAN);
      cmd.commit     = (state_ff == S_FINISH) && out_free;
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd.accept) begin
                  state_ff <= S_START;
                  ready_ff <= 1'b0;
               end
            end
            S_START: begin
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (!stat.scan_busy) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (cmd.commit) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* hdl/sst_dp.sv */
// datapath of the scoped symbol table: entry memories, scope stack, scan and result
`timescale 1ns / 1ps
`default_nettype none

module sst_dp import sst_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sst_cmd_type            cmd,
   output sst_stat_type                stat,
   input  wire logic [CMD_W-1:0]       req_command,
   input  wire logic [KEY_IN_W-1:0]    req_name_key,
   input  wire logic                   req_obj_kind,
   input  wire logic [TYPE_W-1:0]      req_obj_type,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic                        rsp_found_kind,
   output logic [TYPE_W-1:0]           rsp_found_type,
   output logic [LEVEL_W-1:0]          rsp_found_level,
   output logic [ADDR_W-1:0]           rsp_found_addr,
   output logic [DEPTH_OUT_W-1:0]      rsp_depth
);

   // held item
   cmd_code_type        cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                kind_ff;
   logic [TYPE_W-1:0]   type_ff;

   // table state
   logic [COUNT_W-1:0]  count_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [COUNT_W-1:0]  scope_base_ff [MAX_SCOPES];
   logic [ACNT_W-1:0]   scope_next_ff [MAX_SCOPES];
   logic [KEY_BITS-1:0] keys_mem      [MAX_ENTRIES];
   attr_type            attrs_mem     [MAX_ENTRIES];

   // scan pipeline
   logic [COUNT_W-1:0]  idx_ff;
   logic                rd_vld_ff;
   logic [KEY_BITS-1:0] rd_key_ff;
   attr_type            rd_attr_ff;
   logic                hit_ff;
   attr_type            hit_attr_ff;
   logic                dup_ff;

   // result registers
   status_type          out_status_ff;
   attr_type            out_attr_ff;
   logic [DEPTH_W-1:0]  out_depth_ff;

   // decode of current state
   logic [DEPTH_W-1:0]  depth_m1;
   logic [SCOPE_W-1:0]  top_idx;
   logic [SCOPE_W-1:0]  open_idx;
   logic [COUNT_W-1:0]  top_base;
   logic [ACNT_W-1:0]   top_next;
   logic                depth_zero;
   logic                depth_full;
   logic                table_full;
   logic                addr_full;
   logic                issue;
   logic                is_match;

   // commit decisions
   status_type          status_in;
   attr_type            out_attr_in;
   attr_type            new_attr;
   logic [DEPTH_W-1:0]  depth_in;
   logic [COUNT_W-1:0]  count_in;
   logic                do_open;
   logic                do_decl;

   assign depth_m1   = depth_ff - DEPTH_W'(1);
   assign top_idx    = depth_m1[SCOPE_W-1:0];
   assign open_idx   = depth_ff[SCOPE_W-1:0];
   assign top_base   = scope_base_ff[top_idx];
   assign top_next   = scope_next_ff[top_idx];
   assign depth_zero = (depth_ff == '0);
   assign depth_full = (depth_ff == DEPTH_W'(MAX_SCOPES));
   assign table_full = (count_ff == COUNT_W'(MAX_ENTRIES));
   assign addr_full  = (top_next >= ACNT_W'(ADDR_LIMIT));
   assign issue      = cmd.scan_step && (idx_ff < count_ff);
   assign is_match   = rd_vld_ff && (rd_key_ff == key_ff);

   assign stat.scan_busy = (idx_ff < count_ff) || rd_vld_ff;

   // entry built by a declare
   always_comb begin
      new_attr       = '0;
      new_attr.scope = top_idx;
      new_attr.kind  = kind_ff;
      new_attr.typ   = type_ff;
      new_attr.addr  = (kind_ff == KIND_VAR) ? top_next[ADDR_W-1:0] : '0;
   end

   // per-command outcome at commit
   always_comb begin
      status_in   = ST_OK;
      out_attr_in = '0;
      depth_in    = depth_ff;
      count_in    = count_ff;
      do_open     = 1'b0;
      do_decl     = 1'b0;
      case (cmd_ff)
         CMD_OPEN: begin
            if (depth_full) begin
               status_in = ST_FULL;
            end else begin
               do_open  = 1'b1;
               depth_in = depth_ff + DEPTH_W'(1);
            end
         end
         CMD_CLOSE: begin
            if (depth_zero) begin
               status_in = ST_NOSCOPE;
            end else begin
               depth_in = depth_m1;
               count_in = top_base;
            end
         end
         CMD_DECLARE: begin
            if (depth_zero) begin
               status_in = ST_NOSCOPE;
            end else if (table_full || ((kind_ff == KIND_VAR) && addr_full)) begin
               status_in = ST_FULL;
            end else begin
               do_decl     = 1'b1;
               status_in   = dup_ff ? ST_TWICE : ST_OK;
               out_attr_in = new_attr;
               count_in    = count_ff + COUNT_W'(1);
            end
         end
         CMD_FIND: begin
            if (hit_ff) begin
               out_attr_in = hit_attr_ff;
            end else begin
               status_in = ST_UNDECL;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // item capture on transfer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff  <= cmd_code_type'(req_command);
         key_ff  <= KEY_BITS'(req_name_key);
         kind_ff <= req_obj_kind;
         type_ff <= req_obj_type;
      end
   end

   // entry memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && do_decl) begin
         keys_mem[count_ff[INDEX_W-1:0]]  <= key_ff;
         attrs_mem[count_ff[INDEX_W-1:0]] <= new_attr;
      end
      rd_key_ff  <= keys_mem[idx_ff[INDEX_W-1:0]];
      rd_attr_ff <= attrs_mem[idx_ff[INDEX_W-1:0]];
   end

   // scan address, read valid and match tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         dup_ff    <= 1'b0;
      end else if (cmd.scan_start) begin
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         dup_ff    <= 1'b0;
         case (cmd_ff)
            CMD_FIND:    idx_ff <= '0;
            CMD_DECLARE: idx_ff <= depth_zero ? count_ff : top_base;
            default:     idx_ff <= count_ff;
         endcase
      end else begin
         rd_vld_ff <= issue;
         if (issue) begin
            idx_ff <= idx_ff + COUNT_W'(1);
         end
         // a match in a later scope replaces the held one; earliest wins within a scope
         if (is_match) begin
            dup_ff <= 1'b1;
            if (!hit_ff || (rd_attr_ff.scope != hit_attr_ff.scope)) begin
               hit_ff      <= 1'b1;
               hit_attr_ff <= rd_attr_ff;
            end
         end
      end
   end

   // scope stack and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         depth_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_open) begin
         scope_base_ff[open_idx] <= count_ff;
         scope_next_ff[open_idx] <= '0;
      end else if (cmd.commit && do_decl && (kind_ff == KIND_VAR)) begin
         scope_next_ff[top_idx] <= top_next + ACNT_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status_ff <= status_in;
         out_attr_ff   <= out_attr_in;
         out_depth_ff  <= depth_in;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_found_kind  = out_attr_ff.kind;
   assign rsp_found_type  = out_attr_ff.typ;
   assign rsp_found_level = LEVEL_W'(out_attr_ff.scope);
   assign rsp_found_addr  = out_attr_ff.addr;
   assign rsp_depth       = DEPTH_OUT_W'(out_depth_ff);

endmodule

`default_nettype wire

/* hdl/scoped_symbol_table.sv */
// top level of the scoped symbol table
//
//   channel    dir   carries
//   req_chan   in    command, name_key, obj_kind, obj_type
//   rsp_chan   out   status, found_kind, found_type, found_level, found_addr, depth
//
// one item at a time: each item passes the start, scan and finish states from
// transfer to result; open and close scan no entries, a declare scans the
// innermost scope and a find all stored entries, reading one entry per cycle
// from the entry memory through its registered port
// a new item is taken while the previous result still waits; its result is held
// until that one transfers; reset clears counters and state, not the memories
`timescale 1ns / 1ps
`default_nettype none

module scoped_symbol_table import sst_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   sst_req_if.sink  req_chan,
   sst_rsp_if.source rsp_chan
);

   sst_cmd_type  cmd;
   sst_stat_type stat;

   // sequencing of each item
   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // storage, scan and result
   sst_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_chan.command),
      .req_name_key    (req_chan.name_key),
      .req_obj_kind    (req_chan.obj_kind),
      .req_obj_type    (req_chan.obj_type),
      .rsp_status      (rsp_chan.status),
      .rsp_found_kind  (rsp_chan.found_kind),
      .rsp_found_type  (rsp_chan.found_type),
      .rsp_found_level (rsp_chan.found_level),
      .rsp_found_addr  (rsp_chan.found_addr),
      .rsp_depth       (rsp_chan.depth)
   );

endmodule

`default_nettype wire

/* verif/tb_scoped_symbol_table.sv */
// self-checking testbench of the scoped symbol table: directed plan, random bursts, scoreboard
`timescale 1ns / 1ps

module tb_scoped_symbol_table;
   import sst_pkg::*;

   localparam int RANDOM_ITEMS    = 1330;
   localparam int CYCLE_LIMIT     = 1500000;
   localparam int DRAIN_CYCLES    = 120;
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 600;

   // one request item and one reply item
   typedef struct {
      cmd_code_type        cmd;
      logic [KEY_IN_W-1:0] key;
      logic                kind;
      logic [TYPE_W-1:0]   typ;
   } sym_request_type;

   typedef struct {
      status_type             status;
      logic                   kind;
      logic [TYPE_W-1:0]      typ;
      logic [LEVEL_W-1:0]     level;
      logic [ADDR_W-1:0]      addr;
      logic [DEPTH_OUT_W-1:0] depth;
   } sym_reply_type;

   // directed plan row: typed rows carry their reply, the rest are predicted
   typedef struct {
      sym_request_type item;
      bit              typed;
      sym_reply_type   want;
   } plan_row_type;

   typedef enum {MODE_MIX, MODE_NEST, MODE_FILL, MODE_UNWIND} burst_mode_type;

   logic clock;
   logic reset;
   int   cycle_count;
   int   mismatch_count;
   int   replies_seen;
   int   send_calm;
   int   recv_calm;

   sst_req_if req_chan ();
   sst_rsp_if rsp_chan ();

   scoped_symbol_table i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the table
   logic [KEY_BITS-1:0] sym_key   [MAX_ENTRIES];
   logic                sym_kind  [MAX_ENTRIES];
   logic [TYPE_W-1:0]   sym_type  [MAX_ENTRIES];
   logic [LEVEL_W-1:0]  sym_level [MAX_ENTRIES];
   logic [ADDR_W-1:0]   sym_addr  [MAX_ENTRIES];
   int                  sym_count;
   int                  scope_first     [MAX_SCOPES];
   int                  scope_addr_next [MAX_SCOPES];
   int                  scopes_open;

   logic [KEY_IN_W-1:0] key_pool [16];
   sym_reply_type       awaited_replies [$];

   always #2 clock = ~clock;

   function automatic sym_reply_type reply(input status_type st, input logic k,
                                           input logic [TYPE_W-1:0] t,
                                           input logic [LEVEL_W-1:0] lv,
                                           input logic [ADDR_W-1:0] ad,
                                           input logic [DEPTH_OUT_W-1:0] dp);
      sym_reply_type r;
      r.status = st;
      r.kind   = k;
      r.typ    = t;
      r.level  = lv;
      r.addr   = ad;
      r.depth  = dp;
      return r;
   endfunction

   function automatic plan_row_type known_row(input cmd_code_type c, input logic [31:0] key,
                                              input logic k, input logic [TYPE_W-1:0] t,
                                              input sym_reply_type want);
      plan_row_type p;
      p.item.cmd  = c;
      p.item.key  = key;
      p.item.kind = k;
      p.item.typ  = t;
      p.typed     = 1'b1;
      p.want      = want;
      return p;
   endfunction

   function automatic plan_row_type step_row(input cmd_code_type c, input logic [31:0] key,
                                             input logic k, input logic [TYPE_W-1:0] t);
      plan_row_type p;
      p       = known_row(c, key, k, t, reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0));
      p.typed = 1'b0;
      return p;
   endfunction

   // apply one item to the shadow table and return the reply it causes
   function automatic sym_reply_type resolve_item(input sym_request_type it);
      sym_reply_type       r;
      int                  top;
      int                  d;
      int                  last;
      int                  i;
      bit                  hit;
      logic [ADDR_W-1:0]   a;
      logic [KEY_BITS-1:0] key;
      r   = reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0);
      key = it.key[KEY_BITS-1:0];
      case (it.cmd)
         CMD_OPEN: begin
            if (scopes_open >= MAX_SCOPES) begin
               r.status = ST_FULL;
            end else begin
               scope_first[scopes_open]     = sym_count;
               scope_addr_next[scopes_open] = 0;
               scopes_open++;
            end
         end
         CMD_CLOSE: begin
            if (scopes_open == 0) begin
               r.status = ST_NOSCOPE;
            end else begin
               scopes_open--;
               sym_count = scope_first[scopes_open];
            end
         end
         CMD_DECLARE: begin
            if (scopes_open == 0) begin
               r.status = ST_NOSCOPE;
            end else begin
               top = scopes_open - 1;
               if (sym_count >= MAX_ENTRIES ||
                   (it.kind == KIND_VAR && scope_addr_next[top] >= ADDR_LIMIT)) begin
                  r.status = ST_FULL;
               end else begin
                  // duplicate only counts within the innermost scope
                  for (i = scope_first[top]; i < sym_count; i++)
                     if (sym_key[i] == key) r.status = ST_TWICE;
                  a = '0;
                  if (it.kind == KIND_VAR) begin
                     a = scope_addr_next[top][ADDR_W-1:0];
                     scope_addr_next[top]++;
                  end
                  sym_key[sym_count]   = key;
                  sym_kind[sym_count]  = it.kind;
                  sym_type[sym_count]  = it.typ;
                  sym_level[sym_count] = top[LEVEL_W-1:0];
                  sym_addr[sym_count]  = a;
                  sym_count++;
                  r.kind  = it.kind;
                  r.typ   = it.typ;
                  r.level = top[LEVEL_W-1:0];
                  r.addr  = a;
               end
            end
         end
         CMD_FIND: begin
            // innermost scope first, declaration order within a scope
            hit  = 1'b0;
            last = sym_count;
            d    = scopes_open;
            while (d > 0 && !hit) begin
               d--;
               for (i = scope_first[d]; i < last && i < MAX_ENTRIES && !hit; i++) begin
                  if (sym_key[i] == key) begin
                     r.kind  = sym_kind[i];
                     r.typ   = sym_type[i];
                     r.level = sym_level[i];
                     r.addr  = sym_addr[i];
                     hit     = 1'b1;
                  end
               end
               last = scope_first[d];
            end
            if (!hit) r.status = ST_UNDECL;
         end
      endcase
      r.depth = scopes_open[DEPTH_OUT_W-1:0];
      return r;
   endfunction

   // idle cycles for one item, with occasional stretches of none
   function automatic int draw_wait(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic cmd_code_type pick_command(input burst_mode_type mode);
      int roll;
      int o;
      int c;
      int d;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_NEST:   begin o = 60; c = 65; d = 85; end
         MODE_FILL:   begin o = 3;  c = 8;  d = 80; end
         MODE_UNWIND: begin o = 5;  c = 50; d = 70; end
         default:     begin o = 20; c = 35; d = 70; end
      endcase
      if (roll < o) return CMD_OPEN;
      if (roll < c) return CMD_CLOSE;
      if (roll < d) return CMD_DECLARE;
      return CMD_FIND;
   endfunction

   // mostly names from a small pool so that finds and duplicates hit
   function automatic logic [KEY_IN_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(0, 15)] = $urandom();
      if (roll < 60) return key_pool[$urandom_range(0, 15)];
      if (roll < 64) return '0;
      if (roll < 68) return '1;
      if (roll < 70) return 32'h8000_0000;
      return $urandom();
   endfunction

   function automatic void field_ok(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // offer one item, wait for its transfer, record what it should produce
   task automatic send_item(input sym_request_type it, input bit typed,
                            input sym_reply_type want);
      int            gap;
      sym_reply_type predicted;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.command  <= it.cmd;
      req_chan.name_key <= it.key;
      req_chan.obj_kind <= it.kind;
      req_chan.obj_type <= it.typ;
      do @(posedge clock); while (!req_chan.ready);
      predicted = resolve_item(it);
      awaited_replies.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stalls, one long hold-off, compare each transfer
   initial begin
      int            stall;
      sym_reply_type want;
      rsp_chan.ready = 1'b0;
      recv_calm      = 0;
      replies_seen   = 0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_wait(recv_calm);
         if (replies_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            $error("result transfer with no expectation waiting");
            mismatch_count++;
         end else begin
            want = awaited_replies.pop_front();
            field_ok("status", int'(want.status), int'(rsp_chan.status));
            field_ok("found_kind", int'(want.kind), int'(rsp_chan.found_kind));
            field_ok("found_type", int'(want.typ), int'(rsp_chan.found_type));
            field_ok("found_level", int'(want.level), int'(rsp_chan.found_level));
            field_ok("found_addr", int'(want.addr), int'(rsp_chan.found_addr));
            field_ok("depth", int'(want.depth), int'(rsp_chan.depth));
         end
         @(negedge clock);
      end
   end

   // request side: reset, directed plan, random bursts, drain
   initial begin
      plan_row_type    plan [$];
      sym_request_type it;
      burst_mode_type  mode;
      int              burst_len;
      int              sent;
      clock             = 1'b0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.command  = CMD_OPEN;
      req_chan.name_key = '0;
      req_chan.obj_kind = KIND_VAR;
      req_chan.obj_type = TYPE_UNDEF;
      mismatch_count    = 0;
      send_calm         = 0;
      sym_count         = 0;
      scopes_open       = 0;
      foreach (key_pool[n]) key_pool[n] = $urandom();

      // empty table: nothing open
      plan.push_back(known_row(CMD_FIND, 32'h0, KIND_VAR, TYPE_UNDEF,
                               reply(ST_UNDECL, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0)));
      plan.push_back(known_row(CMD_CLOSE, 32'h0, KIND_VAR, TYPE_UNDEF,
                               reply(ST_NOSCOPE, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0)));
      plan.push_back(known_row(CMD_DECLARE, 32'h5, KIND_VAR, TYPE_INT,
                               reply(ST_NOSCOPE, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0)));
      // outer scope, extreme keys, duplicate with type value 3
      plan.push_back(known_row(CMD_OPEN, 32'h0, KIND_VAR, TYPE_UNDEF,
                               reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd1)));
      plan.push_back(known_row(CMD_DECLARE, 32'h0, KIND_VAR, TYPE_INT,
                               reply(ST_OK, KIND_VAR, TYPE_INT, 4'd0, 6'd0, 5'd1)));
      plan.push_back(known_row(CMD_DECLARE, 32'hFFFF_FFFF, KIND_PROC, TYPE_BOOL,
                               reply(ST_OK, KIND_PROC, TYPE_BOOL, 4'd0, 6'd0, 5'd1)));
      plan.push_back(step_row(CMD_DECLARE, 32'h0, KIND_VAR, 2'd3));
      plan.push_back(step_row(CMD_FIND, 32'h0, KIND_VAR, TYPE_UNDEF));
      plan.push_back(known_row(CMD_FIND, 32'h0001_2345, KIND_PROC, TYPE_BOOL,
                               reply(ST_UNDECL, 1'b0, 2'd0, 4'd0, 6'd0, 5'd1)));
      // inner scope shadows the outer one
      plan.push_back(known_row(CMD_OPEN, 32'h0, KIND_VAR, TYPE_UNDEF,
                               reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd2)));
      plan.push_back(step_row(CMD_DECLARE, 32'h0, KIND_VAR, TYPE_BOOL));
      plan.push_back(step_row(CMD_DECLARE, 32'hAAAA_5555, KIND_PROC, TYPE_UNDEF));
      plan.push_back(step_row(CMD_FIND, 32'hFFFF_FFFF, KIND_VAR, TYPE_UNDEF));
      plan.push_back(step_row(CMD_FIND, 32'h0, KIND_VAR, TYPE_UNDEF));
      // close discards the inner entries
      plan.push_back(known_row(CMD_CLOSE, 32'h0, KIND_VAR, TYPE_UNDEF,
                               reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd1)));
      plan.push_back(step_row(CMD_FIND, 32'h0, KIND_VAR, TYPE_UNDEF));
      plan.push_back(known_row(CMD_FIND, 32'hAAAA_5555, KIND_VAR, TYPE_UNDEF,
                               reply(ST_UNDECL, 1'b0, 2'd0, 4'd0, 6'd0, 5'd1)));
      plan.push_back(known_row(CMD_CLOSE, 32'h0, KIND_VAR, TYPE_UNDEF,
                               reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0)));
      plan.push_back(known_row(CMD_FIND, 32'hFFFF_FFFF, KIND_VAR, TYPE_UNDEF,
                               reply(ST_UNDECL, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0)));
      // reopened scope starts its addresses over
      plan.push_back(known_row(CMD_OPEN, 32'h0, KIND_VAR, TYPE_UNDEF,
                               reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd1)));
      plan.push_back(step_row(CMD_DECLARE, 32'h5555_5555, KIND_VAR, TYPE_INT));
      plan.push_back(known_row(CMD_CLOSE, 32'h0, KIND_VAR, TYPE_UNDEF,
                               reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0)));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[n]) send_item(plan[n].item, plan[n].typed, plan[n].want);

      // random bursts: nesting, filling and unwinding reach full scopes and table
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode      = burst_mode_type'($urandom_range(0, 3));
         burst_len = $urandom_range(4, 40);
         repeat (burst_len) begin
            it.cmd  = pick_command(mode);
            it.key  = pick_key();
            it.kind = (mode == MODE_FILL) ? ($urandom_range(0, 4) == 0)
                                          : 1'($urandom_range(0, 1));
            it.typ  = TYPE_W'($urandom_range(0, 3));
            send_item(it, 1'b0, reply(ST_OK, 1'b0, 2'd0, 4'd0, 6'd0, 5'd0));
            sent++;
         end
      end
      req_chan.valid <= 1'b0;

      // drain, then allow for a late stray result
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* scoped_symbol_table.f */
hdl/sst_pkg.sv
hdl/sst_req_if.sv
hdl/sst_rsp_if.sv
hdl/sst_ctrl.sv
hdl/sst_dp.sv
hdl/scoped_symbol_table.sv
verif/tb_scoped_symbol_table.sv
